>>> hdl/sialu_pkg.sv
// shared types and codes for the signed integer alu with power
package sialu_pkg;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;

    // operation codes carried in the request tuser
    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_DIV = 3'd3;
    localparam op_t OP_POW = 3'd4;
    localparam op_t OP_ABS = 3'd5;

    // result status codes
    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_DIVZERO  = 2'd1;
    localparam status_t ST_OVERFLOW = 2'd2;
    localparam status_t ST_UNKNOWN  = 2'd3;

endpackage

>>> hdl/signed_integer_alu_with_power_top.sv
// multicycle signed integer alu: add, subtract, multiply, divide, power, absolute
//
//  channel  direction  tdata (low bit up)              tuser (low bit up)
//  s_*      in         operand_a, operand_b, zero pad  req_type
//  m_*      out        main_value, second_value, pad   reciprocal, status
//
//  add, subtract, absolute and the trivial cases go from dispatch straight to finish.
//  multiply and divide run one shift-add or shift-subtract
//  step a cycle through the single shared DATA_WIDTH+1 bit adder.
//  power runs k base multiplies, each one a full multiply; k stops at the
//  first overflow, so it stays below DATA_WIDTH.
//  reset clears the sequencer and the result valid; a new request is taken once the
//  sequencer is idle, while the previous result may still wait on m_tready.
module signed_integer_alu_with_power_top #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // operand_a, operand_b, zero pad
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    // req_type
    input  logic [sialu_pkg::OP_W-1:0]             s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // main_value, second_value, zero pad
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]      m_tdata,
    // reciprocal, status
    output logic [sialu_pkg::STATUS_W:0]           m_tuser
);

    localparam int DW      = DATA_WIDTH;
    localparam int TDATA_W = ((2*DATA_WIDTH+7)/8)*8;
    localparam int CNT_W   = $clog2(DATA_WIDTH+1);

    localparam logic [DW-1:0] ONE = DW'(1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DISPATCH = 3'd1;
    localparam logic [2:0] ST_MUL      = 3'd2;
    localparam logic [2:0] ST_DIV      = 3'd3;
    localparam logic [2:0] ST_POW      = 3'd4;
    localparam logic [2:0] ST_FINISH   = 3'd5;

    logic [2:0]           state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;

    logic [DW-1:0]        a_reg, a_next;
    logic [DW-1:0]        b_reg, b_next;
    sialu_pkg::op_t       op_reg, op_next;
    logic [DW:0]          hi_reg, hi_next;
    logic [DW-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DW-1:0]        exp_reg, exp_next;

    logic [DW-1:0]        res_mag_reg, res_mag_next;
    logic                 res_neg_reg, res_neg_next;
    logic                 res_plain_reg, res_plain_next;
    logic [DW-1:0]        sec_mag_reg, sec_mag_next;
    logic                 sec_neg_reg, sec_neg_next;
    logic                 recip_reg, recip_next;
    sialu_pkg::status_t   status_reg, status_next;

    logic [DW-1:0]        out_main_reg, out_main_next;
    logic [DW-1:0]        out_second_reg, out_second_next;
    logic                 out_recip_reg, out_recip_next;
    sialu_pkg::status_t   out_status_reg, out_status_next;

    // shared adder / subtractor
    logic [DW:0]          add_x, add_y, add_sum;
    logic                 add_sub;

    logic                 a_neg, b_neg;
    logic [DW-1:0]        a_mag, b_mag;
    logic [DW-1:0]        prod_hi, prod_lo;
    logic [DW:0]          div_shift;
    logic                 div_q;

    logic                 main_ok, sec_ok;
    sialu_pkg::status_t   fin_status;
    logic [DW-1:0]        fin_main, fin_second;

    assign add_sum = add_x + (add_y ^ {(DW+1){add_sub}}) + {{DW{1'b0}}, add_sub};

    assign a_neg = a_reg[DW-1];
    assign b_neg = b_reg[DW-1];
    assign a_mag = a_neg ? (~a_reg + ONE) : a_reg;
    assign b_mag = b_neg ? (~b_reg + ONE) : b_reg;

    assign prod_hi   = add_sum[DW:1];
    assign prod_lo   = {add_sum[0], lo_reg[DW-1:1]};
    assign div_shift = {hi_reg[DW-1:0], lo_reg[DW-1]};
    assign div_q     = ~add_sum[DW];

    // sign-magnitude to two's complement, with range checks
    always_comb
    begin
        main_ok = res_plain_reg || (res_mag_reg == '0)
            || (res_neg_reg ? (!res_mag_reg[DW-1] || (res_mag_reg[DW-2:0] == '0))
                            : !res_mag_reg[DW-1]);
        sec_ok  = (sec_mag_reg == '0)
            || (sec_neg_reg ? (!sec_mag_reg[DW-1] || (sec_mag_reg[DW-2:0] == '0))
                            : !sec_mag_reg[DW-1]);
        if (status_reg != sialu_pkg::ST_OK)
            fin_status = status_reg;
        else if (main_ok && sec_ok)
            fin_status = sialu_pkg::ST_OK;
        else
            fin_status = sialu_pkg::ST_OVERFLOW;
        fin_main   = (!res_plain_reg && res_neg_reg) ? (~res_mag_reg + ONE) : res_mag_reg;
        fin_second = sec_neg_reg ? (~sec_mag_reg + ONE) : sec_mag_reg;
        if (fin_status != sialu_pkg::ST_OK)
        begin
            fin_main   = '0;
            fin_second = '0;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        op_next         = op_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        cnt_next        = cnt_reg;
        exp_next        = exp_reg;
        res_mag_next    = res_mag_reg;
        res_neg_next    = res_neg_reg;
        res_plain_next  = res_plain_reg;
        sec_mag_next    = sec_mag_reg;
        sec_neg_next    = sec_neg_reg;
        recip_next      = recip_reg;
        status_next     = status_reg;
        out_main_next   = out_main_reg;
        out_second_next = out_second_reg;
        out_recip_next  = out_recip_reg;
        out_status_next = out_status_reg;
        add_x           = '0;
        add_y           = '0;
        add_sub         = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    a_next     = s_tdata[DW-1:0];
                    b_next     = s_tdata[2*DW-1:DW];
                    op_next    = s_tuser;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                res_mag_next   = '0;
                res_neg_next   = 1'b0;
                res_plain_next = 1'b0;
                sec_mag_next   = '0;
                sec_neg_next   = 1'b0;
                recip_next     = 1'b0;
                status_next    = sialu_pkg::ST_OK;
                unique case (op_reg)
                    sialu_pkg::OP_ADD, sialu_pkg::OP_SUB:
                    begin
                        add_x          = {a_reg[DW-1], a_reg};
                        add_y          = {b_reg[DW-1], b_reg};
                        add_sub        = (op_reg == sialu_pkg::OP_SUB);
                        res_mag_next   = add_sum[DW-1:0];
                        res_plain_next = 1'b1;
                        if (add_sum[DW] != add_sum[DW-1])
                            status_next = sialu_pkg::ST_OVERFLOW;
                        state_next = ST_FINISH;
                    end
                    sialu_pkg::OP_MUL:
                    begin
                        hi_next    = '0;
                        lo_next    = b_mag;
                        cnt_next   = CNT_W'(DATA_WIDTH);
                        state_next = ST_MUL;
                    end
                    sialu_pkg::OP_DIV:
                    begin
                        if (b_mag == '0)
                        begin
                            status_next = sialu_pkg::ST_DIVZERO;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            hi_next    = '0;
                            lo_next    = a_mag;
                            cnt_next   = CNT_W'(DATA_WIDTH);
                            state_next = ST_DIV;
                        end
                    end
                    sialu_pkg::OP_POW:
                    begin
                        if (b_mag == '0)
                        begin
                            res_mag_next = ONE;
                            state_next   = ST_FINISH;
                        end
                        else if ((a_mag == '0) && b_neg)
                        begin
                            status_next = sialu_pkg::ST_DIVZERO;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            // a base of 0 or 1 needs no multiplies
                            lo_next    = a_mag;
                            exp_next   = (a_mag[DW-1:1] == '0) ? ONE : b_mag;
                            state_next = ST_POW;
                        end
                    end
                    sialu_pkg::OP_ABS:
                    begin
                        res_mag_next = a_mag;
                        sec_mag_next = b_mag;
                        state_next   = ST_FINISH;
                    end
                    default:
                    begin
                        status_next = sialu_pkg::ST_UNKNOWN;
                        state_next  = ST_FINISH;
                    end
                endcase
            end
            ST_MUL:
            begin
                // shift-add, multiplier in lo, multiplicand is |a|
                add_x    = hi_reg;
                add_y    = lo_reg[0] ? {1'b0, a_mag} : '0;
                hi_next  = {1'b0, prod_hi};
                lo_next  = prod_lo;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    if (op_reg == sialu_pkg::OP_POW)
                    begin
                        // running power may reach the top magnitude, never pass it
                        if ((prod_hi != '0) || (prod_lo[DW-1] && (prod_lo[DW-2:0] != '0)))
                        begin
                            status_next = sialu_pkg::ST_OVERFLOW;
                            state_next  = ST_FINISH;
                        end
                        else
                        begin
                            exp_next   = exp_reg - ONE;
                            state_next = ST_POW;
                        end
                    end
                    else
                    begin
                        res_mag_next = prod_lo;
                        res_neg_next = a_neg ^ b_neg;
                        if (prod_hi != '0)
                            status_next = sialu_pkg::ST_OVERFLOW;
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV:
            begin
                // restoring step, quotient bits shift into lo
                add_x    = div_shift;
                add_y    = {1'b0, b_mag};
                add_sub  = 1'b1;
                hi_next  = div_q ? add_sum : div_shift;
                lo_next  = {lo_reg[DW-2:0], div_q};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    res_mag_next = {lo_reg[DW-2:0], div_q};
                    res_neg_next = a_neg ^ b_neg;
                    sec_mag_next = div_q ? add_sum[DW-1:0] : div_shift[DW-1:0];
                    sec_neg_next = a_neg;
                    state_next   = ST_FINISH;
                end
            end
            ST_POW:
            begin
                if (exp_reg[DW-1:1] != '0)
                begin
                    hi_next    = '0;
                    cnt_next   = CNT_W'(DATA_WIDTH);
                    state_next = ST_MUL;
                end
                else
                begin
                    res_mag_next = lo_reg;
                    res_neg_next = a_neg & b_reg[0];
                    recip_next   = b_neg;
                    state_next   = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_main_next   = fin_main;
                    out_second_next = fin_second;
                    out_recip_next  = (fin_status == sialu_pkg::ST_OK) && recip_reg;
                    out_status_next = fin_status;
                    out_valid_next  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg          <= a_next;
        b_reg          <= b_next;
        op_reg         <= op_next;
        hi_reg         <= hi_next;
        lo_reg         <= lo_next;
        cnt_reg        <= cnt_next;
        exp_reg        <= exp_next;
        res_mag_reg    <= res_mag_next;
        res_neg_reg    <= res_neg_next;
        res_plain_reg  <= res_plain_next;
        sec_mag_reg    <= sec_mag_next;
        sec_neg_reg    <= sec_neg_next;
        recip_reg      <= recip_next;
        status_reg     <= status_next;
        out_main_reg   <= out_main_next;
        out_second_reg <= out_second_next;
        out_recip_reg  <= out_recip_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_second_reg, out_main_reg});
    assign m_tuser  = {out_status_reg, out_recip_reg};

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg == ST_DISPATCH)
        else $error("accepted request did not reach dispatch");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_status_reg != sialu_pkg::ST_OK)
        |-> (out_main_reg == '0) && (out_second_reg == '0) && !out_recip_reg)
        else $error("error result carries a nonzero payload");

    a_recip_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_recip_reg |-> out_status_reg == sialu_pkg::ST_OK)
        else $error("reciprocal flag set on a failed result");

    a_step_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL) || (state_reg == ST_DIV) |-> cnt_reg != '0)
        else $error("step counter ran out inside multiply or divide");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) && out_valid_reg && !m_tready |=> state_reg == ST_FINISH)
        else $error("finished result left before the output was free");

endmodule
